// ===== rtl/plc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the piecewise linear curve block.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int unsigned MaxPointsDefault = 32;
  localparam int unsigned MaxPointsLimit   = 256;
  localparam int unsigned IdxMaxW          = $clog2(MaxPointsLimit);
  localparam int unsigned CntMaxW          = $clog2(MaxPointsLimit + 1);
  localparam int unsigned DataW            = 32;
  localparam int unsigned SlotW            = 5;
  localparam int unsigned QuoW             = DataW + 1;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_SET    = 2'd2,
    KIND_EVAL   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FIRST_D,
    B_LAST_D,
    B_SCAN_D,
    B_SETUP,
    B_MUL,
    B_DIV
  } back_state_e;

  // one classified request travelling from front to back
  typedef struct packed {
    kind_e                     kind;
    logic                      we;
    logic [IdxMaxW-1:0]        waddr;
    logic signed [DataW-1:0]   position;
    logic signed [DataW-1:0]   point_value;
    logic                      status;
    logic [SlotW-1:0]          slot_used;
    logic [CntMaxW-1:0]        count;
  } req_t;

endpackage

// ===== rtl/piecewise_linear_curve_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_top
// Breakpoint table with clamped linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; two requests can
// wait in the queue while the back end works. Every request gives one result,
// shown for one cycle with done_o, in request order; the receiver cannot stall.
// Clear, append and set write the table, if at all, as they are popped, and
// then strobe. Evaluate answers with the default value on an empty table,
// clamps at the first point or else at the last point, and otherwise reads
// the table through the single RAM read port to find the segment
// (1 <= reads < MaxPoints), then does setup, one multiply and a restoring
// division (33 quotient bits, then one step to emit the result).
// A request waiting in the queue adds the remaining time of the one ahead.
// There is no clearing pass after reset.
module piecewise_linear_curve_top #(
  parameter int unsigned MaxPoints = plc_pkg::MaxPointsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind_i,
  input  logic [plc_pkg::SlotW-1:0]        slot_i,
  input  logic signed [plc_pkg::DataW-1:0] position_i,
  input  logic signed [plc_pkg::DataW-1:0] point_value_i,
  input  logic                             cfg_we_i,
  input  logic signed [plc_pkg::DataW-1:0] cfg_wdata_i,
  output logic                             done_o,
  output logic signed [plc_pkg::DataW-1:0] result_value_o,
  output logic                             status_o,
  output logic [plc_pkg::SlotW-1:0]        slot_used_o
);

  localparam int unsigned IdxW = $clog2(MaxPoints);

  plc_pkg::req_t front_req, head_req;
  logic accept, full, empty, pop;
  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [2*plc_pkg::DataW-1:0] ram_wdata, ram_rdata;

  assign busy   = full;
  assign accept = start && !full;

  plc_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .kind_i, .slot_i, .position_i,
    .point_value_i, .req_o(front_req)
  );

  plc_queue u_queue (
    .clk_i, .rst_ni, .push_i(accept), .req_i(front_req), .full_o(full),
    .pop_i(pop), .empty_o(empty), .req_o(head_req)
  );

  plc_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .empty_i(empty), .req_i(head_req),
    .pop_o(pop), .ram_we_o(ram_we), .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata), .ram_raddr_o(ram_raddr), .ram_rdata_i(ram_rdata),
    .done_o, .result_value_o, .status_o, .slot_used_o
  );

  plc_ram #(.Width(2 * plc_pkg::DataW), .Depth(MaxPoints)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

endmodule

// ===== rtl/plc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module plc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/plc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_front
// Accepts requests, tracks the point count and classifies table writes.
// ----------------------------------------------------------------------------
module plc_front #(
  parameter int unsigned MaxPoints = plc_pkg::MaxPointsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [1:0]                       kind_i,
  input  logic [plc_pkg::SlotW-1:0]        slot_i,
  input  logic signed [plc_pkg::DataW-1:0] position_i,
  input  logic signed [plc_pkg::DataW-1:0] point_value_i,
  output plc_pkg::req_t                    req_o
);

  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [plc_pkg::CntMaxW-1:0] count_ext;
  logic [plc_pkg::CntMaxW-1:0] slot_ext;

  assign count_ext = plc_pkg::CntMaxW'(count_q);
  assign slot_ext  = plc_pkg::CntMaxW'(slot_i);

  // classify the request against the current count
  always_comb begin
    count_d           = count_q;
    req_o             = '0;
    req_o.kind        = plc_pkg::kind_e'(kind_i);
    req_o.position    = position_i;
    req_o.point_value = point_value_i;
    req_o.count       = count_ext;
    unique case (plc_pkg::kind_e'(kind_i))
      plc_pkg::KIND_CLEAR: begin
        count_d = '0;
      end
      plc_pkg::KIND_APPEND: begin
        if (count_ext < plc_pkg::CntMaxW'(MaxPoints)) begin
          req_o.we        = 1'b1;
          req_o.waddr     = plc_pkg::IdxMaxW'(count_q);
          req_o.slot_used = plc_pkg::SlotW'(count_q);
          count_d         = count_q + CntW'(1);
        end else begin
          req_o.status = 1'b1;
        end
      end
      plc_pkg::KIND_SET: begin
        if (slot_ext < count_ext && slot_ext < plc_pkg::CntMaxW'(MaxPoints)) begin
          req_o.we        = 1'b1;
          req_o.waddr     = plc_pkg::IdxMaxW'(slot_i);
          req_o.slot_used = slot_i;
        end else begin
          req_o.status = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/plc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module plc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  plc_pkg::req_t req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output plc_pkg::req_t req_o
);

  plc_pkg::req_t entry_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    fill_q;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign req_o   = entry_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= req_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== rtl/plc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_back
// Executes queued requests: table writes, segment search, multiply and
// restoring division, and drives the result strobe.
// ----------------------------------------------------------------------------
module plc_back #(
  parameter int unsigned MaxPoints = plc_pkg::MaxPointsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [plc_pkg::DataW-1:0]    cfg_wdata_i,
  input  logic                                empty_i,
  input  plc_pkg::req_t                       req_i,
  output logic                                pop_o,
  output logic                                ram_we_o,
  output logic [$clog2(MaxPoints)-1:0]        ram_waddr_o,
  output logic [2*plc_pkg::DataW-1:0]         ram_wdata_o,
  output logic [$clog2(MaxPoints)-1:0]        ram_raddr_o,
  input  logic [2*plc_pkg::DataW-1:0]         ram_rdata_i,
  output logic                                done_o,
  output logic signed [plc_pkg::DataW-1:0]    result_value_o,
  output logic                                status_o,
  output logic [plc_pkg::SlotW-1:0]           slot_used_o
);

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned DW   = plc_pkg::DataW;
  localparam int unsigned QW   = plc_pkg::QuoW;

  plc_pkg::back_state_e state_q, state_d;

  logic signed [DW-1:0] dflt_q;
  logic signed [DW-1:0] x_q, x_d;
  logic [plc_pkg::CntMaxW-1:0] n_q, n_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic signed [DW-1:0] p0_q, p0_d, v0_q, v0_d, p1_q, p1_d, v1_q, v1_d;
  logic [QW-1:0]  mag_q, mag_d;
  logic [DW-1:0]  dx_q, dx_d, dp_q, dp_d;
  logic           neg_q, neg_d;
  logic [DW-1:0]  rem_q, rem_d;
  logic [QW-1:0]  num_q, num_d, quo_q, quo_d;
  logic [5:0]     step_q, step_d;
  logic           done_q, done_d, status_q, status_d;
  logic signed [DW-1:0] res_q, res_d;
  logic [plc_pkg::SlotW-1:0] used_q, used_d;

  logic signed [DW-1:0] rd_pos, rd_val;
  logic signed [DW:0]   dv_full;
  logic [2*DW:0]        product;
  logic [QW-1:0]        trial;
  logic                 trial_ge;
  logic [DW-1:0]        q_lo;

  assign rd_pos   = ram_rdata_i[2*DW-1:DW];
  assign rd_val   = ram_rdata_i[DW-1:0];
  assign dv_full  = (DW+1)'(v1_q) - (DW+1)'(v0_q);
  assign product  = (2*DW+1)'(mag_q) * (2*DW+1)'(dx_q);
  assign trial    = {rem_q, num_q[QW-1]};
  assign trial_ge = (trial >= QW'(dp_q));
  assign q_lo     = quo_q[DW-1:0];

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    x_d = x_q; n_d = n_q; idx_d = idx_q;
    p0_d = p0_q; v0_d = v0_q; p1_d = p1_q; v1_d = v1_q;
    mag_d = mag_q; dx_d = dx_q; dp_d = dp_q; neg_d = neg_q;
    rem_d = rem_q; num_d = num_q; quo_d = quo_q; step_d = step_q;
    done_d = 1'b0; status_d = status_q; res_d = res_q; used_d = used_q;
    unique case (state_q)
      plc_pkg::B_IDLE: begin
        if (!empty_i) begin
          if (req_i.kind != plc_pkg::KIND_EVAL) begin
            done_d   = 1'b1;
            res_d    = '0;
            status_d = req_i.status;
            used_d   = req_i.slot_used;
          end else if (req_i.count == '0) begin
            done_d   = 1'b1;
            res_d    = dflt_q;
            status_d = 1'b0;
            used_d   = '0;
          end else begin
            x_d     = req_i.position;
            n_d     = req_i.count;
            state_d = plc_pkg::B_FIRST_D;
          end
        end
      end
      plc_pkg::B_FIRST_D: begin
        p0_d = rd_pos;
        v0_d = rd_val;
        if (n_q == plc_pkg::CntMaxW'(1) || x_q <= rd_pos) begin
          done_d = 1'b1; res_d = rd_val; status_d = 1'b0; used_d = '0;
          state_d = plc_pkg::B_IDLE;
        end else begin
          state_d = plc_pkg::B_LAST_D;
        end
      end
      plc_pkg::B_LAST_D: begin
        if (x_q >= rd_pos) begin
          done_d = 1'b1; res_d = rd_val; status_d = 1'b0; used_d = '0;
          state_d = plc_pkg::B_IDLE;
        end else begin
          idx_d   = IdxW'(1);
          state_d = plc_pkg::B_SCAN_D;
        end
      end
      plc_pkg::B_SCAN_D: begin
        if (x_q < rd_pos) begin
          p1_d    = rd_pos;
          v1_d    = rd_val;
          state_d = plc_pkg::B_SETUP;
        end else begin
          p0_d  = rd_pos;
          v0_d  = rd_val;
          idx_d = idx_q + IdxW'(1);
        end
      end
      plc_pkg::B_SETUP: begin
        neg_d   = dv_full[DW];
        mag_d   = dv_full[DW] ? QW'(-dv_full) : QW'(dv_full);
        dx_d    = DW'(x_q - p0_q);
        dp_d    = DW'(p1_q - p0_q);
        state_d = plc_pkg::B_MUL;
      end
      plc_pkg::B_MUL: begin
        rem_d   = product[2*DW:QW];
        num_d   = product[QW-1:0];
        quo_d   = '0;
        step_d  = '0;
        state_d = plc_pkg::B_DIV;
      end
      plc_pkg::B_DIV: begin
        rem_d  = trial_ge ? DW'(trial - QW'(dp_q)) : DW'(trial);
        quo_d  = {quo_q[QW-2:0], trial_ge};
        num_d  = {num_q[QW-2:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == 6'(QW)) begin
          done_d   = 1'b1;
          res_d    = neg_q ? (v0_q - $signed(q_lo)) : (v0_q + $signed(q_lo));
          status_d = 1'b0;
          used_d   = '0;
          rem_d    = rem_q;
          quo_d    = quo_q;
          state_d  = plc_pkg::B_IDLE;
        end
      end
      default: state_d = plc_pkg::B_IDLE;
    endcase
  end

  // queue pop, table write and read address
  always_comb begin
    pop_o       = (state_q == plc_pkg::B_IDLE) && !empty_i;
    ram_we_o    = pop_o && req_i.we;
    ram_waddr_o = IdxW'(req_i.waddr);
    ram_wdata_o = {req_i.position, req_i.point_value};
    unique case (state_q)
      plc_pkg::B_FIRST_D: ram_raddr_o = IdxW'(n_q - plc_pkg::CntMaxW'(1));
      plc_pkg::B_LAST_D:  ram_raddr_o = IdxW'(1);
      plc_pkg::B_SCAN_D:  ram_raddr_o = idx_q + IdxW'(1);
      default:            ram_raddr_o = '0;
    endcase
  end

  // the division finishes in the cycle after its last quotient bit
  // (step equal to the quotient width only emits the result)

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plc_pkg::B_IDLE;
      done_q  <= 1'b0;
      dflt_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) dflt_q <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d; n_q <= n_d; idx_q <= idx_d;
    p0_q <= p0_d; v0_q <= v0_d; p1_q <= p1_d; v1_q <= v1_d;
    mag_q <= mag_d; dx_q <= dx_d; dp_q <= dp_d; neg_q <= neg_d;
    rem_q <= rem_d; num_q <= num_d; quo_q <= quo_d; step_q <= step_d;
    status_q <= status_d; res_q <= res_d; used_q <= used_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign slot_used_o    = used_q;

endmodule

// ===== rtl/plc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the curve block, bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic signed [plc_pkg::DataW-1:0] result_value_o,
  input logic                             status_o,
  input logic [plc_pkg::SlotW-1:0]        slot_used_o
);

  logic [2:0] pending_q;

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(start && !busy) - 3'(done_o);
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pending_q != 3'd0) else $error("result without request");

  a_bounded_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3) else $error("too many requests in flight");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> slot_used_o == '0 && result_value_o == '0)
    else $error("failed write reports data");

endmodule

bind piecewise_linear_curve_top plc_checker u_plc_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .result_value_o, .status_o,
  .slot_used_o
);
